### src/uvsg_pkg.sv
// Shared constants, types and tables for the UV-sphere vertex generator.
// No dependencies; every other file in src refers to it by scoped names.
package uvsg_pkg;

   localparam int INDEX_BITS        = 10;
   localparam int CORDIC_ITERATIONS = 16;

   localparam int FRAC_BITS   = 16;
   localparam int UV_BITS     = FRAC_BITS + 1;
   localparam int PHASE_BITS  = FRAC_BITS + 2;
   localparam int REM_BITS    = INDEX_BITS + 1;
   localparam int RADIUS_BITS = 16;
   localparam int CFG_BITS    = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int POS_BITS    = 17;
   localparam int NORM_BITS   = 16;
   localparam int MAG_BITS    = 32;
   localparam int ANG_BITS    = 34;
   localparam int TRIG_BITS   = 32;
   localparam int PM_BITS     = 49;
   localparam int ATAN_DEPTH  = 24;
   localparam int ATAN_IDX_BITS = 5;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_STACK_COUNT  = 2'd0,
      CSR_SECTOR_COUNT = 2'd1,
      CSR_RADIUS       = 2'd2
   } csr_index_type;

   localparam logic [INDEX_BITS-1:0]  STACK_COUNT_RESET  = INDEX_BITS'(16);
   localparam logic [INDEX_BITS-1:0]  SECTOR_COUNT_RESET = INDEX_BITS'(32);
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET       = RADIUS_BITS'(256);

   localparam logic [UV_BITS-1:0]    UV_ONE       = UV_BITS'(1 << FRAC_BITS);
   localparam logic [PHASE_BITS-1:0] QUARTER_TURN = PHASE_BITS'(1 << FRAC_BITS);
   localparam logic [PHASE_BITS-1:0] HALF_TURN    = PHASE_BITS'(2 << FRAC_BITS);
   localparam logic [PHASE_BITS-1:0] THREE_QUARTER_TURN = PHASE_BITS'(3 << FRAC_BITS);

   localparam logic [MAG_BITS-1:0]        PI_Q30   = 32'd3373259426;
   localparam logic signed [ANG_BITS-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [63:0] ONE_Q30    = 64'sd1073741824;
   localparam logic signed [63:0] HALF_Q30   = 64'sd536870912;
   localparam logic signed [63:0] HALF_Q16   = 64'sd32768;
   localparam logic signed [63:0] NORM_LIMIT = 64'sd16384;
   localparam logic signed [63:0] POS_LIMIT  = 64'sd65535;

   // quotient bits resolved per stage in the two index dividers
   localparam int DIV_STEPS     = FRAC_BITS + 1;
   localparam int DIV_PER_STAGE = 4;
   localparam int DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

   localparam int CORDIC_PER_STAGE = 2;
   localparam int CORDIC_STAGES    =
      (CORDIC_ITERATIONS + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE;

   // pipeline stage numbers
   localparam int S_IN   = 0;
   localparam int S_DIV0 = S_IN + 1;
   localparam int S_PH   = S_DIV0 + DIV_STAGES;
   localparam int S_ANG  = S_PH + 1;
   localparam int S_FLIP = S_ANG + CORDIC_STAGES + 1;
   localparam int S_MUL  = S_FLIP + 1;
   localparam int S_DIR  = S_MUL + 1;
   localparam int S_PMUL = S_DIR + 1;
   localparam int S_OUT  = S_PMUL + 1;
   localparam int S_NUM  = S_OUT + 1;

   typedef logic [MAG_BITS-1:0] atan_table_type [ATAN_DEPTH];
   localparam atan_table_type ATAN_Q30 = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
      32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
      32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
      32'd127
   };

endpackage

### src/uvsg_req_if.sv
// Request channel: one grid point per transfer.
// Depends on uvsg_pkg for the index width.
interface uvsg_req_if;
   logic                            valid;
   logic                            ready;
   logic [uvsg_pkg::INDEX_BITS-1:0] stack_index;
   logic [uvsg_pkg::INDEX_BITS-1:0] sector_index;

   modport source (output valid, stack_index, sector_index, input ready);
   modport sink   (input valid, stack_index, sector_index, output ready);
endinterface

### src/uvsg_rsp_if.sv
// Response channel: one vertex (position, normal, texture, error) per transfer.
// Depends on uvsg_pkg for field widths.
interface uvsg_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [uvsg_pkg::POS_BITS-1:0]  pos_x;
   logic signed [uvsg_pkg::POS_BITS-1:0]  pos_y;
   logic signed [uvsg_pkg::POS_BITS-1:0]  pos_z;
   logic signed [uvsg_pkg::NORM_BITS-1:0] norm_x;
   logic signed [uvsg_pkg::NORM_BITS-1:0] norm_y;
   logic signed [uvsg_pkg::NORM_BITS-1:0] norm_z;
   logic [uvsg_pkg::UV_BITS-1:0]          tex_u;
   logic [uvsg_pkg::UV_BITS-1:0]          tex_v;
   logic                                  index_error;

   modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   tex_u, tex_v, index_error, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   tex_u, tex_v, index_error, output ready);
endinterface

### src/uv_sphere_vertex_generator.sv
// UV-sphere vertex generator: a 21-stage pipeline that takes one grid point
// (stack, sector) per cycle and returns position, normal and texture coordinates,
// one vertex per cycle, both while the output is not stalled. Most stages sit in
// the two index dividers (4 quotient bits per stage, 5 stages), the pair of
// CORDIC rotators (2 iterations per stage, 8 stages) and the multiply, round
// and scale stages behind them. Every stage holds its item while the stage ahead
// cannot take one, so empty slots fill while a finished vertex waits on the output.
// Write configuration only while no item is in flight: the dividers and the
// radius scaling read the registers directly.
// Depends on uvsg_pkg, uvsg_req_if and uvsg_rsp_if.
module uv_sphere_vertex_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [uvsg_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [uvsg_pkg::CFG_BITS-1:0]       csr_wdata,
   uvsg_req_if.sink                            req_ch,
   uvsg_rsp_if.source                          rsp_ch
);

   typedef struct packed {
      logic [uvsg_pkg::REM_BITS-1:0] rem;
      logic [uvsg_pkg::UV_BITS-1:0]  q;
   } div_type;

   typedef struct packed {
      logic                          flip;
      logic                          neg;
      logic [uvsg_pkg::UV_BITS-1:0]  absr;
   } fold_type;

   typedef struct packed {
      logic signed [uvsg_pkg::ANG_BITS-1:0] x;
      logic signed [uvsg_pkg::ANG_BITS-1:0] y;
      logic signed [uvsg_pkg::ANG_BITS-1:0] z;
   } rot_type;

   function automatic div_type div_steps(input logic [uvsg_pkg::REM_BITS-1:0] rem,
                                         input logic [uvsg_pkg::UV_BITS-1:0] q,
                                         input logic [uvsg_pkg::INDEX_BITS-1:0] den,
                                         input int first);
      div_type r;
      int      g;
      r.rem = rem;
      r.q   = q;
      for (int j = 0; j < uvsg_pkg::DIV_PER_STAGE; j++) begin
         g = first + j;
         if (g < uvsg_pkg::DIV_STEPS) begin
            if (g != 0) begin
               r.rem = {r.rem[uvsg_pkg::REM_BITS-2:0], 1'b0};
            end
            if (r.rem >= {1'b0, den}) begin
               r.rem = r.rem - {1'b0, den};
               r.q   = {r.q[uvsg_pkg::UV_BITS-2:0], 1'b1};
            end else begin
               r.q   = {r.q[uvsg_pkg::UV_BITS-2:0], 1'b0};
            end
         end
      end
      return r;
   endfunction

   // fold into [-1/4, 1/4] turn; flip marks a removed half turn
   function automatic fold_type fold_phase(input logic [uvsg_pkg::PHASE_BITS-1:0] p);
      fold_type                        f;
      logic [uvsg_pkg::PHASE_BITS-1:0] q;
      logic [uvsg_pkg::PHASE_BITS-1:0] nq;
      f.flip = (p >= uvsg_pkg::QUARTER_TURN) && (p < uvsg_pkg::THREE_QUARTER_TURN);
      q      = f.flip ? p - uvsg_pkg::HALF_TURN : p;
      nq     = uvsg_pkg::PHASE_BITS'(0) - q;
      f.neg  = q >= uvsg_pkg::THREE_QUARTER_TURN;
      f.absr = f.neg ? nq[uvsg_pkg::UV_BITS-1:0] : q[uvsg_pkg::UV_BITS-1:0];
      return f;
   endfunction

   function automatic rot_type cordic_stage(input rot_type a, input int first);
      rot_type                        r;
      logic signed [uvsg_pkg::ANG_BITS-1:0] at;
      logic signed [uvsg_pkg::ANG_BITS-1:0] xs;
      logic signed [uvsg_pkg::ANG_BITS-1:0] ys;
      int                             i;
      r = a;
      for (int j = 0; j < uvsg_pkg::CORDIC_PER_STAGE; j++) begin
         i = first + j;
         if (i < uvsg_pkg::CORDIC_ITERATIONS) begin
            at = $signed({{(uvsg_pkg::ANG_BITS-uvsg_pkg::MAG_BITS){1'b0}},
                          uvsg_pkg::ATAN_Q30[uvsg_pkg::ATAN_IDX_BITS'(i)]});
            xs = r.x >>> i;
            ys = r.y >>> i;
            if (r.z >= 0) begin
               r.x = r.x - ys;
               r.y = r.y + xs;
               r.z = r.z - at;
            end else begin
               r.x = r.x + ys;
               r.y = r.y - xs;
               r.z = r.z + at;
            end
         end
      end
      return r;
   endfunction

   function automatic logic signed [63:0] clamp_s64(input logic signed [63:0] v,
                                                    input logic signed [63:0] lim);
      if (v > lim) begin
         return lim;
      end else if (v < -lim) begin
         return -lim;
      end
      return v;
   endfunction

   function automatic logic signed [uvsg_pkg::TRIG_BITS-1:0] finish_trig(
         input logic signed [uvsg_pkg::ANG_BITS-1:0] v, input logic flip);
      logic signed [63:0] c;
      c = clamp_s64(64'(v), uvsg_pkg::ONE_Q30);
      if (flip) begin
         c = -c;
      end
      return uvsg_pkg::TRIG_BITS'(c);
   endfunction

   function automatic rot_type start_rot(input logic [uvsg_pkg::MAG_BITS-1:0] mag,
                                         input logic neg);
      rot_type                              r;
      logic signed [uvsg_pkg::ANG_BITS-1:0] m;
      m   = $signed({{(uvsg_pkg::ANG_BITS-uvsg_pkg::MAG_BITS){1'b0}}, mag});
      r.x = uvsg_pkg::GAIN_Q30;
      r.y = '0;
      r.z = neg ? -m : m;
      return r;
   endfunction

   // ---------------- configuration ----------------
   logic [uvsg_pkg::INDEX_BITS-1:0]  stack_count_ff;
   logic [uvsg_pkg::INDEX_BITS-1:0]  sector_count_ff;
   logic [uvsg_pkg::RADIUS_BITS-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff  <= uvsg_pkg::STACK_COUNT_RESET;
         sector_count_ff <= uvsg_pkg::SECTOR_COUNT_RESET;
         radius_ff       <= uvsg_pkg::RADIUS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            uvsg_pkg::CSR_STACK_COUNT:  stack_count_ff  <= csr_wdata[uvsg_pkg::INDEX_BITS-1:0];
            uvsg_pkg::CSR_SECTOR_COUNT: sector_count_ff <= csr_wdata[uvsg_pkg::INDEX_BITS-1:0];
            uvsg_pkg::CSR_RADIUS:       radius_ff       <= csr_wdata[uvsg_pkg::RADIUS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic [uvsg_pkg::S_NUM-1:0] vld_ff;
   logic [uvsg_pkg::S_NUM:0]   rdy;
   logic [uvsg_pkg::S_NUM-1:0] err_ff;
   logic                       err_in;

   assign rdy[uvsg_pkg::S_NUM] = rsp_ch.ready;
   for (genvar s = 0; s < uvsg_pkg::S_NUM; s++) begin : g_rdy
      // a stage takes a new item when empty or when its item moves on
      assign rdy[s] = !vld_ff[s] || rdy[s+1];
   end
   assign req_ch.ready = rdy[0];

   assign err_in = (stack_count_ff == '0) || (sector_count_ff == '0) ||
                   (req_ch.stack_index > stack_count_ff) ||
                   (req_ch.sector_index > sector_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_ch.valid;
         end
         for (int s = 1; s < uvsg_pkg::S_NUM; s++) begin
            if (rdy[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         err_ff[0] <= err_in;
      end
      for (int s = 1; s < uvsg_pkg::S_NUM; s++) begin
         if (rdy[s]) begin
            err_ff[s] <= err_ff[s-1];
         end
      end
   end

   // ---------------- u = sector/count, v = stack/count ----------------
   logic [uvsg_pkg::UV_BITS-1:0]  u_ff [uvsg_pkg::S_OUT];
   logic [uvsg_pkg::UV_BITS-1:0]  u_in [uvsg_pkg::S_OUT];
   logic [uvsg_pkg::UV_BITS-1:0]  v_ff [uvsg_pkg::S_OUT];
   logic [uvsg_pkg::UV_BITS-1:0]  v_in [uvsg_pkg::S_OUT];
   logic [uvsg_pkg::REM_BITS-1:0] rem_u_ff [uvsg_pkg::DIV_STAGES];
   logic [uvsg_pkg::REM_BITS-1:0] rem_u_in [uvsg_pkg::DIV_STAGES];
   logic [uvsg_pkg::REM_BITS-1:0] rem_v_ff [uvsg_pkg::DIV_STAGES];
   logic [uvsg_pkg::REM_BITS-1:0] rem_v_in [uvsg_pkg::DIV_STAGES];

   assign u_in[0]     = '0;
   assign v_in[0]     = '0;
   assign rem_u_in[0] = {1'b0, req_ch.sector_index};
   assign rem_v_in[0] = {1'b0, req_ch.stack_index};

   for (genvar k = 1; k < uvsg_pkg::S_OUT; k++) begin : g_uv
      if (k >= uvsg_pkg::S_DIV0 && k < uvsg_pkg::S_DIV0 + uvsg_pkg::DIV_STAGES) begin : g_div
         localparam int D = k - uvsg_pkg::S_DIV0;
         div_type du;
         div_type dv;
         assign du = div_steps(rem_u_ff[D], u_ff[k-1], sector_count_ff,
                               D * uvsg_pkg::DIV_PER_STAGE);
         assign dv = div_steps(rem_v_ff[D], v_ff[k-1], stack_count_ff,
                               D * uvsg_pkg::DIV_PER_STAGE);
         assign u_in[k] = du.q;
         assign v_in[k] = dv.q;
         if (D + 1 < uvsg_pkg::DIV_STAGES) begin : g_rem
            assign rem_u_in[D+1] = du.rem;
            assign rem_v_in[D+1] = dv.rem;
         end
      end else begin : g_pass
         assign u_in[k] = u_ff[k-1];
         assign v_in[k] = v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < uvsg_pkg::S_OUT; s++) begin
         if (rdy[s]) begin
            u_ff[s] <= u_in[s];
            v_ff[s] <= v_in[s];
         end
      end
      // remainder register d sits in stage d
      for (int d = 0; d < uvsg_pkg::DIV_STAGES; d++) begin
         if (rdy[uvsg_pkg::S_IN + d]) begin
            rem_u_ff[d] <= rem_u_in[d];
            rem_v_ff[d] <= rem_v_in[d];
         end
      end
   end

   // ---------------- phase fold and angle in radians ----------------
   logic [uvsg_pkg::PHASE_BITS-1:0]         lat_phase;
   logic [uvsg_pkg::PHASE_BITS-1:0]         lon_phase;
   fold_type                                lat_fold;
   fold_type                                lon_fold;
   logic [uvsg_pkg::UV_BITS+uvsg_pkg::MAG_BITS-1:0] lat_prod;
   logic [uvsg_pkg::UV_BITS+uvsg_pkg::MAG_BITS-1:0] lon_prod;
   logic [uvsg_pkg::MAG_BITS-1:0]           lat_mag_ff;
   logic [uvsg_pkg::MAG_BITS-1:0]           lon_mag_ff;
   logic                                    lat_neg_ff;
   logic                                    lon_neg_ff;
   logic                                    lat_flip_ff [uvsg_pkg::S_PH:uvsg_pkg::S_FLIP-1];
   logic                                    lon_flip_ff [uvsg_pkg::S_PH:uvsg_pkg::S_FLIP-1];

   assign lat_phase = uvsg_pkg::QUARTER_TURN - {v_ff[uvsg_pkg::S_PH-1], 1'b0};
   assign lon_phase = {u_ff[uvsg_pkg::S_PH-1][uvsg_pkg::FRAC_BITS-1:0], 2'b00};
   assign lat_fold  = fold_phase(lat_phase);
   assign lon_fold  = fold_phase(lon_phase);
   assign lat_prod  = (uvsg_pkg::UV_BITS+uvsg_pkg::MAG_BITS)'(lat_fold.absr) *
                      (uvsg_pkg::UV_BITS+uvsg_pkg::MAG_BITS)'(uvsg_pkg::PI_Q30);
   assign lon_prod  = (uvsg_pkg::UV_BITS+uvsg_pkg::MAG_BITS)'(lon_fold.absr) *
                      (uvsg_pkg::UV_BITS+uvsg_pkg::MAG_BITS)'(uvsg_pkg::PI_Q30);

   always_ff @(posedge clock) begin
      if (rdy[uvsg_pkg::S_PH]) begin
         lat_mag_ff <= lat_prod[uvsg_pkg::UV_BITS+uvsg_pkg::MAG_BITS-1:uvsg_pkg::UV_BITS];
         lon_mag_ff <= lon_prod[uvsg_pkg::UV_BITS+uvsg_pkg::MAG_BITS-1:uvsg_pkg::UV_BITS];
         lat_neg_ff <= lat_fold.neg;
         lon_neg_ff <= lon_fold.neg;
         lat_flip_ff[uvsg_pkg::S_PH] <= lat_fold.flip;
         lon_flip_ff[uvsg_pkg::S_PH] <= lon_fold.flip;
      end
      for (int s = uvsg_pkg::S_PH + 1; s < uvsg_pkg::S_FLIP; s++) begin
         if (rdy[s]) begin
            lat_flip_ff[s] <= lat_flip_ff[s-1];
            lon_flip_ff[s] <= lon_flip_ff[s-1];
         end
      end
   end

   // ---------------- CORDIC rotators ----------------
   rot_type lat_ff [uvsg_pkg::CORDIC_STAGES+1];
   rot_type lat_in [uvsg_pkg::CORDIC_STAGES+1];
   rot_type lon_ff [uvsg_pkg::CORDIC_STAGES+1];
   rot_type lon_in [uvsg_pkg::CORDIC_STAGES+1];

   assign lat_in[0] = start_rot(lat_mag_ff, lat_neg_ff);
   assign lon_in[0] = start_rot(lon_mag_ff, lon_neg_ff);

   for (genvar c = 1; c <= uvsg_pkg::CORDIC_STAGES; c++) begin : g_cordic
      assign lat_in[c] = cordic_stage(lat_ff[c-1], (c-1) * uvsg_pkg::CORDIC_PER_STAGE);
      assign lon_in[c] = cordic_stage(lon_ff[c-1], (c-1) * uvsg_pkg::CORDIC_PER_STAGE);
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c <= uvsg_pkg::CORDIC_STAGES; c++) begin
         if (rdy[uvsg_pkg::S_ANG + c]) begin
            lat_ff[c] <= lat_in[c];
            lon_ff[c] <= lon_in[c];
         end
      end
   end

   // ---------------- direction ----------------
   logic signed [uvsg_pkg::TRIG_BITS-1:0] clat_ff, slat_ff, clon_ff, slon_ff;
   logic signed [63:0]                    prod_x_ff, prod_z_ff;
   logic signed [uvsg_pkg::TRIG_BITS-1:0] slat_m_ff;
   logic signed [uvsg_pkg::TRIG_BITS-1:0] dx_ff, dy_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (rdy[uvsg_pkg::S_FLIP]) begin
         clat_ff <= finish_trig(lat_ff[uvsg_pkg::CORDIC_STAGES].x,
                                lat_flip_ff[uvsg_pkg::S_FLIP-1]);
         slat_ff <= finish_trig(lat_ff[uvsg_pkg::CORDIC_STAGES].y,
                                lat_flip_ff[uvsg_pkg::S_FLIP-1]);
         clon_ff <= finish_trig(lon_ff[uvsg_pkg::CORDIC_STAGES].x,
                                lon_flip_ff[uvsg_pkg::S_FLIP-1]);
         slon_ff <= finish_trig(lon_ff[uvsg_pkg::CORDIC_STAGES].y,
                                lon_flip_ff[uvsg_pkg::S_FLIP-1]);
      end
      if (rdy[uvsg_pkg::S_MUL]) begin
         prod_x_ff <= 64'(clat_ff) * 64'(clon_ff);
         prod_z_ff <= 64'(clat_ff) * 64'(slon_ff);
         slat_m_ff <= slat_ff;
      end
      if (rdy[uvsg_pkg::S_DIR]) begin
         dx_ff <= uvsg_pkg::TRIG_BITS'(clamp_s64((prod_x_ff + uvsg_pkg::HALF_Q30) >>> 30,
                                                 uvsg_pkg::ONE_Q30));
         dz_ff <= uvsg_pkg::TRIG_BITS'(clamp_s64((prod_z_ff + uvsg_pkg::HALF_Q30) >>> 30,
                                                 uvsg_pkg::ONE_Q30));
         dy_ff <= slat_m_ff;
      end
   end

   // ---------------- scale by radius, normals ----------------
   logic signed [uvsg_pkg::PM_BITS-1:0]   pm_x_ff, pm_y_ff, pm_z_ff;
   logic signed [uvsg_pkg::NORM_BITS-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [63:0]                    radius_s;

   assign radius_s = 64'($signed({1'b0, radius_ff}));

   always_ff @(posedge clock) begin
      if (rdy[uvsg_pkg::S_PMUL]) begin
         pm_x_ff <= uvsg_pkg::PM_BITS'(radius_s * 64'(dx_ff));
         pm_y_ff <= uvsg_pkg::PM_BITS'(radius_s * 64'(dy_ff));
         pm_z_ff <= uvsg_pkg::PM_BITS'(radius_s * 64'(dz_ff));
         nx_ff <= uvsg_pkg::NORM_BITS'(clamp_s64((64'(dx_ff) + uvsg_pkg::HALF_Q16) >>> 16,
                                                 uvsg_pkg::NORM_LIMIT));
         ny_ff <= uvsg_pkg::NORM_BITS'(clamp_s64((64'(dy_ff) + uvsg_pkg::HALF_Q16) >>> 16,
                                                 uvsg_pkg::NORM_LIMIT));
         nz_ff <= uvsg_pkg::NORM_BITS'(clamp_s64((64'(dz_ff) + uvsg_pkg::HALF_Q16) >>> 16,
                                                 uvsg_pkg::NORM_LIMIT));
      end
   end

   // ---------------- output register ----------------
   logic signed [uvsg_pkg::POS_BITS-1:0]  out_pos_x_ff, out_pos_y_ff, out_pos_z_ff;
   logic signed [uvsg_pkg::NORM_BITS-1:0] out_nx_ff, out_ny_ff, out_nz_ff;
   logic [uvsg_pkg::UV_BITS-1:0]          out_u_ff, out_v_ff;
   logic                                  out_err;

   assign out_err = err_ff[uvsg_pkg::S_OUT-1];

   always_ff @(posedge clock) begin
      if (rdy[uvsg_pkg::S_OUT]) begin
         // zero all attributes of a flagged point (index above its count, or a zero count)
         if (out_err) begin
            out_pos_x_ff <= '0;
            out_pos_y_ff <= '0;
            out_pos_z_ff <= '0;
            out_nx_ff    <= '0;
            out_ny_ff    <= '0;
            out_nz_ff    <= '0;
            out_u_ff     <= '0;
            out_v_ff     <= '0;
         end else begin
            out_pos_x_ff <= uvsg_pkg::POS_BITS'(clamp_s64(
                               (64'(pm_x_ff) + uvsg_pkg::HALF_Q30) >>> 30, uvsg_pkg::POS_LIMIT));
            out_pos_y_ff <= uvsg_pkg::POS_BITS'(clamp_s64(
                               (64'(pm_y_ff) + uvsg_pkg::HALF_Q30) >>> 30, uvsg_pkg::POS_LIMIT));
            out_pos_z_ff <= uvsg_pkg::POS_BITS'(clamp_s64(
                               (64'(pm_z_ff) + uvsg_pkg::HALF_Q30) >>> 30, uvsg_pkg::POS_LIMIT));
            out_nx_ff    <= nx_ff;
            out_ny_ff    <= ny_ff;
            out_nz_ff    <= nz_ff;
            out_u_ff     <= u_ff[uvsg_pkg::S_OUT-1];
            out_v_ff     <= v_ff[uvsg_pkg::S_OUT-1];
         end
      end
   end

   assign rsp_ch.valid       = vld_ff[uvsg_pkg::S_OUT];
   assign rsp_ch.pos_x       = out_pos_x_ff;
   assign rsp_ch.pos_y       = out_pos_y_ff;
   assign rsp_ch.pos_z       = out_pos_z_ff;
   assign rsp_ch.norm_x      = out_nx_ff;
   assign rsp_ch.norm_y      = out_ny_ff;
   assign rsp_ch.norm_z      = out_nz_ff;
   assign rsp_ch.tex_u       = out_u_ff;
   assign rsp_ch.tex_v       = out_v_ff;
   assign rsp_ch.index_error = err_ff[uvsg_pkg::S_OUT];

   // ---------------- assertions ----------------
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.index_error |->
         rsp_ch.pos_x == '0 && rsp_ch.pos_y == '0 && rsp_ch.pos_z == '0 &&
         rsp_ch.norm_x == '0 && rsp_ch.norm_y == '0 && rsp_ch.norm_z == '0 &&
         rsp_ch.tex_u == '0 && rsp_ch.tex_v == '0)
      else $error("error vertex carries nonzero attributes");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         rsp_ch.norm_x <= 16384 && rsp_ch.norm_x >= -16384 &&
         rsp_ch.norm_y <= 16384 && rsp_ch.norm_y >= -16384 &&
         rsp_ch.norm_z <= 16384 && rsp_ch.norm_z >= -16384)
      else $error("normal component out of unit range");

   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.index_error |->
         rsp_ch.tex_u <= uvsg_pkg::UV_ONE && rsp_ch.tex_v <= uvsg_pkg::UV_ONE)
      else $error("texture coordinate above one");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&vld_ff) && !rsp_ch.ready |-> !req_ch.ready)
      else $error("full pipeline accepted a transfer while stalled");

endmodule
